// ----- sv/fpcvt_pkg.sv -----
// Shared types and constants for the single/double <-> extended converter.
`default_nettype none
package fpcvt_pkg;

  localparam int unsigned EXT_BIAS = 16383;
  localparam int unsigned SGL_BIAS = 127;
  localparam int unsigned DBL_BIAS = 1023;

  localparam logic [1:0] CMD_S2X = 2'd0;
  localparam logic [1:0] CMD_D2X = 2'd1;
  localparam logic [1:0] CMD_X2S = 2'd2;
  localparam logic [1:0] CMD_X2D = 2'd3;

  localparam logic [1:0] RND_NEAREST = 2'd0;
  localparam logic [1:0] RND_DOWN    = 2'd1;
  localparam logic [1:0] RND_UP      = 2'd2;
  localparam logic [1:0] RND_CHOP    = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] source_bits;
    logic [63:0] ext_mantissa;
    logic [15:0] ext_sign_exponent;
  } cvt_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic [63:0] result_mantissa;
    logic [15:0] result_sign_exponent;
  } cvt_out_t;

  typedef struct packed {
    logic       to_double;
    logic [1:0] mode;
  } nrw_ctl_t;

endpackage
`default_nettype wire

// ----- sv/fp_single_double_extended_convert_core.sv -----
// Top level: single/double <-> 80-bit extended format converter.
//
// Input: a word on in_data is taken at a rising edge with start high and
// busy low. busy is always low: a new word may be issued every cycle.
// Output: each word yields one result, shown on out_data for exactly one
// cycle with out_strobe high. The word passes the input register, then
// the result register; the strobe rises as the result register is loaded.
// Throughput is one word per cycle.
// The receiver cannot hold results off; results leave in issue order.
// Unused result fields are zero: result_bits for widening commands,
// result_mantissa and result_sign_exponent for narrowing ones.
// cfg_we/cfg_wdata write the rounding mode (nearest, down, up, chop); it
// is used by narrowing words in the result stage, so write it only when no
// word is in flight.
// Reset (rst_n low, synchronous) clears the rounding mode to nearest and
// drops any words in flight; no strobe follows reset until new words come.
`default_nettype none
module fp_single_double_extended_convert_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire fpcvt_pkg::cvt_in_t  in_data,
  output logic                     out_strobe,
  output fpcvt_pkg::cvt_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_wdata
);

  logic [1:0]           rnd_mode_r;
  logic                 in_vld_r;
  fpcvt_pkg::cvt_in_t   in_r;
  logic                 out_vld_r;
  fpcvt_pkg::cvt_out_t  out_r;
  fpcvt_pkg::cvt_out_t  out_nxt;
  fpcvt_pkg::nrw_ctl_t  nrw_ctl;
  logic [63:0]          wide_man;
  logic [15:0]          wide_se;
  logic [63:0]          nrw_bits;
  logic                 is_widen;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_mode_r <= fpcvt_pkg::RND_NEAREST;
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        rnd_mode_r <= cfg_wdata;
      end
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  fpcvt_widen u_widen (
    .from_double   (in_r.command == fpcvt_pkg::CMD_D2X),
    .source_bits   (in_r.source_bits),
    .mantissa      (wide_man),
    .sign_exponent (wide_se)
  );

  assign nrw_ctl.to_double = (in_r.command == fpcvt_pkg::CMD_X2D);
  assign nrw_ctl.mode      = rnd_mode_r;

  fpcvt_narrow u_narrow (
    .ctl               (nrw_ctl),
    .ext_mantissa      (in_r.ext_mantissa),
    .ext_sign_exponent (in_r.ext_sign_exponent),
    .result_bits       (nrw_bits)
  );

  assign is_widen = (in_r.command == fpcvt_pkg::CMD_S2X) ||
                    (in_r.command == fpcvt_pkg::CMD_D2X);

  always_comb begin
    if (is_widen) begin
      out_nxt.result_bits          = 64'd0;
      out_nxt.result_mantissa      = wide_man;
      out_nxt.result_sign_exponent = wide_se;
    end else begin
      out_nxt.result_bits          = nrw_bits;
      out_nxt.result_mantissa      = 64'd0;
      out_nxt.result_sign_exponent = 16'd0;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

  // every accepted word comes out through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_strobe)
    else $error("accepted word produced no result");

  // no result without a matching accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result strobe without accepted word");

  // widening and narrowing fields never both carry data
  a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.result_bits == 64'd0) ||
                   ((out_data.result_mantissa == 64'd0) &&
                    (out_data.result_sign_exponent == 16'd0)))
    else $error("both result field groups nonzero");

  // rounding mode only changes through a config write
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_we) |-> $stable(rnd_mode_r))
    else $error("rounding mode changed without write");

endmodule
`default_nettype wire

// ----- sv/fpcvt_widen.sv -----
// Single or double to extended: rebias exponent, insert explicit leading one.
`default_nettype none
module fpcvt_widen (
  input  wire logic        from_double,
  input  wire logic [63:0] source_bits,
  output logic      [63:0] mantissa,
  output logic      [15:0] sign_exponent
);

  logic        sign;
  logic        is_zero;
  logic [14:0] exp_s;
  logic [14:0] exp_d;

  assign exp_s = 15'(source_bits[30:23]) + 15'(fpcvt_pkg::EXT_BIAS - fpcvt_pkg::SGL_BIAS);
  assign exp_d = 15'(source_bits[62:52]) + 15'(fpcvt_pkg::EXT_BIAS - fpcvt_pkg::DBL_BIAS);

  always_comb begin
    if (from_double) begin
      sign    = source_bits[63];
      is_zero = (source_bits[62:0] == 63'd0);
    end else begin
      sign    = source_bits[31];
      is_zero = (source_bits[30:0] == 31'd0);
    end

    if (is_zero) begin
      mantissa      = 64'd0;
      sign_exponent = {sign, 15'd0};
    end else if (from_double) begin
      mantissa      = {1'b1, source_bits[51:0], 11'd0};
      sign_exponent = {sign, exp_d};
    end else begin
      mantissa      = {1'b1, source_bits[22:0], 40'd0};
      sign_exponent = {sign, exp_s};
    end
  end

endmodule
`default_nettype wire

// ----- sv/fpcvt_narrow.sv -----
// Extended to single or double: rebias, drop leading one, round, pack.
`default_nettype none
module fpcvt_narrow (
  input  wire fpcvt_pkg::nrw_ctl_t ctl,
  input  wire logic [63:0]         ext_mantissa,
  input  wire logic [15:0]         ext_sign_exponent,
  output logic      [63:0]         result_bits
);

  logic        neg;
  logic [14:0] ex;
  logic [31:0] base_s;
  logic [63:0] base_d;
  logic [10:0] dropped;
  logic [10:0] half;
  logic        inc;
  logic [63:0] sum;

  assign neg = ext_sign_exponent[15];
  assign ex  = ext_sign_exponent[14:0];

  // rebias mod 2^8 / 2^11 reduces to flipping the top kept exponent bit
  assign base_s = {neg, ex[7:0] ^ 8'h80, ext_mantissa[62:40]};
  assign base_d = {neg, ex[10:0] ^ 11'h400, ext_mantissa[62:11]};

  // single looks only at the 8 bits below the high-word fraction
  assign dropped = ctl.to_double ? ext_mantissa[10:0] : {3'd0, ext_mantissa[39:32]};
  assign half    = ctl.to_double ? 11'h400 : 11'h080;

  always_comb begin
    case (ctl.mode)
      fpcvt_pkg::RND_NEAREST: inc = (dropped > half);
      fpcvt_pkg::RND_DOWN:    inc = neg && (dropped != 11'd0);
      fpcvt_pkg::RND_UP:      inc = !neg && (dropped != 11'd0);
      fpcvt_pkg::RND_CHOP:    inc = 1'b0;
      default:                inc = 1'b0;
    endcase
  end

  // carry runs into the exponent field
  assign sum = (ctl.to_double ? base_d : {32'd0, base_s}) + {63'd0, inc};

  always_comb begin
    if (ex == 15'd0) begin
      result_bits = ctl.to_double ? {neg, 63'd0} : {32'd0, neg, 31'd0};
    end else if (ctl.to_double) begin
      result_bits = sum;
    end else begin
      result_bits = {32'd0, sum[31:0]};
    end
  end

endmodule
`default_nettype wire
